// File: rtl/acso_pkg.sv
// shared constants for the arctangent soft clipper
// drive limits, cordic angle table and default sizes; no dependencies
package acso_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ATAN_ITER_DEF   = 16;
    localparam int DRIVE_W         = 13;
    localparam int ANGLE_W         = 32;
    localparam int CORDIC_GUARD    = 15;
    localparam int TAB_DEPTH       = 32;
    localparam int TAB_AW          = 5;

    typedef logic [DRIVE_W-1:0] t_drive;

    localparam t_drive DRIVE_MIN   = 13'd1;
    localparam t_drive DRIVE_MAX   = 13'd7680;
    localparam t_drive DRIVE_RESET = 13'd256;

    // atan(2^-i) / (pi/2) scaled by 2^30
    localparam logic signed [ANGLE_W-1:0] ATAN_TAB [TAB_DEPTH] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81,
        32'sd41,        32'sd20,        32'sd10,        32'sd5,
        32'sd3,         32'sd1,         32'sd1,         32'sd0
    };

endpackage

// File: rtl/acso_in_if.sv
// input channel of the soft clipper: valid/ready with sample and drive fields
// depends on acso_pkg
interface acso_in_if #(
    parameter int SAMPLE_BITS = acso_pkg::SAMPLE_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_BITS-1:0]   sample_in;
    logic                            mod_valid;
    logic [acso_pkg::DRIVE_W-1:0]    mod_drive;

    modport source (output valid, sample_in, mod_valid, mod_drive, input ready);
    modport sink   (input valid, sample_in, mod_valid, mod_drive, output ready);
endinterface

// File: rtl/acso_out_if.sv
// output channel of the soft clipper: valid/ready with the shaped sample
// depends on acso_pkg
interface acso_out_if #(
    parameter int SAMPLE_BITS = acso_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);
endinterface

// File: rtl/arctan_soft_clip_overdrive.sv
// top level of the arctangent soft clipper: drive handling, sequencer, rounding
// depends on acso_pkg, acso_in_if, acso_out_if and acso_cordic
//
//  channel      dir   handshake        payload
//  i_in         in    valid / ready    sample_in, mod_valid, mod_drive
//  o_out        out   valid / ready    sample_out
//  drive_gain   in    i_drive_gain_we  i_drive_gain (13 bit q5.8)
//
// an accepted item steps through ST_MUL, ST_LOAD, ST_RUN and ST_DONE before o_out.valid,
// with the cordic loop doing one micro-rotation per cycle in ST_RUN
// i_in.ready is high only while no item is in work
// a stalled result waits in the output register; the next item is taken meanwhile
// synchronous active low reset; drive returns to 1.0
module arctan_soft_clip_overdrive #(
    parameter int SAMPLE_BITS     = acso_pkg::SAMPLE_BITS_DEF,
    parameter int ATAN_ITERATIONS = acso_pkg::ATAN_ITER_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    acso_in_if.sink                          i_in,
    acso_out_if.source                       o_out,
    input  logic                             i_drive_gain_we,
    input  logic [acso_pkg::DRIVE_W-1:0]     i_drive_gain
);
    localparam int W  = SAMPLE_BITS + acso_pkg::CORDIC_GUARD;
    localparam int PW = SAMPLE_BITS + acso_pkg::DRIVE_W + 1;
    localparam int MW = acso_pkg::ANGLE_W + 2;
    localparam int SH  = acso_pkg::ANGLE_W - 2 - (SAMPLE_BITS - 1);
    localparam int RSH = (SH > 0) ? SH : 0;
    localparam int LSH = (SH < 0) ? -SH : 0;
    localparam logic [MW-1:0] RND  = (MW'(1) << RSH) >> 1;
    localparam logic [MW-1:0] FULL = (MW'(1) << (SAMPLE_BITS - 1)) - MW'(1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_RUN  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    function automatic acso_pkg::t_drive clamp_drive(input acso_pkg::t_drive v);
        if (v < acso_pkg::DRIVE_MIN) begin
            return acso_pkg::DRIVE_MIN;
        end else if (v > acso_pkg::DRIVE_MAX) begin
            return acso_pkg::DRIVE_MAX;
        end else begin
            return v;
        end
    endfunction

    logic [2:0]                          r_state;
    acso_pkg::t_drive                    r_drive;
    logic signed [SAMPLE_BITS-1:0]       r_sample;
    logic signed [W-1:0]                 r_y0;
    logic signed [PW-1:0]                prod;
    logic                                r_out_valid;
    logic signed [SAMPLE_BITS-1:0]       r_out_data;
    logic                                cordic_done;
    logic signed [acso_pkg::ANGLE_W-1:0] angle;
    logic                                neg;
    logic [MW-1:0]                       ang_ext, mag, scaled, sat, res;
    logic                                in_fire, out_load;

    assign in_fire  = i_in.valid && (r_state == ST_IDLE);
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);
    assign prod     = r_sample * $signed({1'b0, r_drive});

    acso_cordic #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .ATAN_ITERATIONS (ATAN_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_LOAD),
        .i_y0    (r_y0),
        .o_done  (cordic_done),
        .o_angle (angle)
    );

    // round to nearest, ties away from zero, then clamp
    always_comb begin
        neg     = angle[acso_pkg::ANGLE_W-1];
        ang_ext = MW'(angle);
        mag     = neg ? (MW'(0) - ang_ext) : ang_ext;
        scaled  = ((mag + RND) >> RSH) << LSH;
        sat     = (scaled > FULL) ? FULL : scaled;
        res     = neg ? (MW'(0) - sat) : sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_drive     <= acso_pkg::DRIVE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire && i_in.mod_valid) begin
                r_drive <= clamp_drive(i_in.mod_drive);
            end else if (i_drive_gain_we) begin
                r_drive <= clamp_drive(i_drive_gain);
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL:  r_state <= ST_LOAD;
                ST_LOAD: r_state <= ST_RUN;
                ST_RUN: begin
                    if (cordic_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sample <= i_in.sample_in;
        end
        if (r_state == ST_MUL) begin
            r_y0 <= W'(prod);
        end
        if (out_load) begin
            r_out_data <= res[SAMPLE_BITS-1:0];
        end
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_data;
endmodule

// File: rtl/acso_cordic.sv
// iterative vectoring cordic, one micro-rotation per cycle on a shared adder set
// depends on acso_pkg for the angle table
module acso_cordic #(
    parameter int SAMPLE_BITS     = acso_pkg::SAMPLE_BITS_DEF,
    parameter int ATAN_ITERATIONS = acso_pkg::ATAN_ITER_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [SAMPLE_BITS+acso_pkg::CORDIC_GUARD-1:0] i_y0,
    output logic                                o_done,
    output logic signed [acso_pkg::ANGLE_W-1:0] o_angle
);
    localparam int W  = SAMPLE_BITS + acso_pkg::CORDIC_GUARD;
    localparam int IW = $clog2(ATAN_ITERATIONS);
    localparam logic [IW-1:0] LAST = IW'(ATAN_ITERATIONS - 1);
    localparam logic signed [W-1:0] X0 = W'(1) <<< (SAMPLE_BITS + 7);

    logic signed [W-1:0]                r_x, r_y, n_x, n_y, dx, dy;
    logic signed [acso_pkg::ANGLE_W-1:0] r_z, n_z, step;
    logic [IW-1:0]                      r_i;
    logic                               r_busy, r_done;

    always_comb begin
        dx   = r_y >>> r_i;
        dy   = r_x >>> r_i;
        step = acso_pkg::ATAN_TAB[acso_pkg::TAB_AW'(r_i)];
        if (!r_y[W-1]) begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + step;
        end else begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_i == LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= X0;
            r_y <= i_y0;
            r_z <= '0;
            r_i <= '0;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_i <= r_i + IW'(1);
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_z;
endmodule

// File: rtl/acso_checker.sv
// port-level checks for the arctangent soft clipper, bound to the top level
// depends on acso_pkg and arctan_soft_clip_overdrive
module acso_checker #(
    parameter int SAMPLE_BITS = acso_pkg::SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_out_data
);
    localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    // the cordic runs between accept and result, so no result straight after accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> !i_out_valid)
        else $error("result appeared one cycle after accept");

    a_result_symmetric: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data != MOST_NEG))
        else $error("result outside the clamped range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result dropped or changed");
endmodule

bind arctan_soft_clip_overdrive acso_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_acso_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.sample_out)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench for arctan_soft_clip_overdrive: directed and random items against a cordic predictor
// depends on acso_pkg, acso_in_if, acso_out_if and the block itself
module tb_top;

    localparam int SB          = 16;
    localparam int ITER        = 16;
    localparam int ANGLE_FRAC  = 30;
    localparam int ROUND_SH    = ANGLE_FRAC - (SB - 1);
    localparam int LATENCY     = ITER + 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 100;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_drive_gain_we;
    logic [acso_pkg::DRIVE_W-1:0] i_drive_gain;

    acso_in_if  #(.SAMPLE_BITS(SB)) sample_in_ch ();
    acso_out_if #(.SAMPLE_BITS(SB)) sample_out_ch ();

    arctan_soft_clip_overdrive #(
        .SAMPLE_BITS(SB),
        .ATAN_ITERATIONS(ITER)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(sample_in_ch),
        .o_out(sample_out_ch),
        .i_drive_gain_we(i_drive_gain_we),
        .i_drive_gain(i_drive_gain)
    );

    logic signed [SB-1:0] shaped_q [$];
    acso_pkg::t_drive drive_now;
    bit     quiet_mode;
    int     err_count;
    int     item_count;
    int     checked_count;
    int     gain_writes;
    int     mod_items;
    int     cycle_count;
    logic signed [SB-1:0] shaped_exp;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cycle limit reached with %0d items pending", shaped_q.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic acso_pkg::t_drive sat_drive(input logic [acso_pkg::DRIVE_W-1:0] v);
        if (v < acso_pkg::DRIVE_MIN) return acso_pkg::DRIVE_MIN;
        if (v > acso_pkg::DRIVE_MAX) return acso_pkg::DRIVE_MAX;
        return v;
    endfunction

    // atan(sample * drive) / (pi/2) by vectoring cordic, rounded to q1.15
    function automatic logic signed [SB-1:0] arctan_shape(input logic signed [SB-1:0] smp,
                                                          input acso_pkg::t_drive drv);
        longint y;
        longint x;
        longint z;
        longint dx;
        longint dy;
        longint mag;
        longint res;
        bit     neg;
        y = longint'(smp) * longint'(drv);
        x = longint'(1) << (SB - 1 + 8);
        z = 0;
        for (int i = 0; i < ITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(acso_pkg::ATAN_TAB[i]);
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(acso_pkg::ATAN_TAB[i]);
            end
        end
        neg = (z < 0);
        mag = neg ? -z : z;
        mag = (mag + (longint'(1) << (ROUND_SH - 1))) >>> ROUND_SH;
        if (mag > (longint'(1) << (SB - 1)) - 1) mag = (longint'(1) << (SB - 1)) - 1;
        res = neg ? -mag : mag;
        return res[SB-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic signed [SB-1:0] got,
                                   input logic signed [SB-1:0] want);
        err_count++;
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    always @(negedge i_clk) begin
        sample_out_ch.ready <= quiet_mode || ($urandom_range(99) >= 12);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && sample_out_ch.valid && sample_out_ch.ready) begin
            if (shaped_q.size() == 0) begin
                report_mismatch("unexpected item", sample_out_ch.sample_out, '0);
            end else begin
                shaped_exp = shaped_q.pop_front();
                checked_count++;
                if (sample_out_ch.sample_out !== shaped_exp) begin
                    report_mismatch("sample_out", sample_out_ch.sample_out, shaped_exp);
                end
            end
        end
    end

    task automatic send_item(input logic signed [SB-1:0] smp, input logic mv,
                             input logic [acso_pkg::DRIVE_W-1:0] md);
        @(negedge i_clk);
        while (!quiet_mode && $urandom_range(99) < 12) begin
            sample_in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        sample_in_ch.valid     <= 1'b1;
        sample_in_ch.sample_in <= smp;
        sample_in_ch.mod_valid <= mv;
        sample_in_ch.mod_drive <= md;
        do @(posedge i_clk); while (!sample_in_ch.ready);
        if (mv) begin
            drive_now = sat_drive(md);
            mod_items++;
        end
        shaped_q.push_back(arctan_shape(smp, drive_now));
        item_count++;
    endtask

    // block is idle once every pending item has come out
    task automatic wait_drained();
        @(negedge i_clk);
        sample_in_ch.valid <= 1'b0;
        while (shaped_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_drive_gain(input logic [acso_pkg::DRIVE_W-1:0] v);
        wait_drained();
        i_drive_gain_we <= 1'b1;
        i_drive_gain    <= v;
        @(negedge i_clk);
        i_drive_gain_we <= 1'b0;
        drive_now = sat_drive(v);
        gain_writes++;
    endtask

    task automatic test_default_drive();
        send_item(16'sh0000, 1'b0, 13'h1fff);
        send_item(16'sh7fff, 1'b0, 13'h0000);
        send_item(16'sh8000, 1'b0, 13'h1fff);
        send_item(16'sh0001, 1'b0, 13'h0000);
        send_item(16'shffff, 1'b0, 13'h0000);
    endtask

    task automatic test_drive_register();
        write_drive_gain(13'd0);
        send_item(16'sh7fff, 1'b0, 13'h0000);
        send_item(16'sh8000, 1'b0, 13'h0000);
        write_drive_gain(13'h1fff);
        send_item(16'sh7fff, 1'b0, 13'h0000);
        send_item(16'sh8000, 1'b0, 13'h0000);
        send_item(16'sh0001, 1'b0, 13'h0000);
        write_drive_gain(acso_pkg::DRIVE_MAX);
        send_item(16'shffff, 1'b0, 13'h0000);
        write_drive_gain(acso_pkg::DRIVE_MIN);
        send_item(16'sh7fff, 1'b0, 13'h0000);
    endtask

    task automatic test_mod_drive();
        write_drive_gain(acso_pkg::DRIVE_RESET);
        send_item(16'sh7fff, 1'b1, 13'd0);
        // drive kept after the modulated item
        send_item(16'sh7fff, 1'b0, 13'h1fff);
        send_item(16'sh8000, 1'b1, 13'h1fff);
        send_item(16'sh0064, 1'b1, 13'd7681);
        send_item(16'sh0001, 1'b1, acso_pkg::DRIVE_MAX);
        send_item(16'sh8000, 1'b1, acso_pkg::DRIVE_MIN);
        send_item(16'sh5555, 1'b1, 13'h1555);
        send_item(16'shaaaa, 1'b1, 13'h0aaa);
        send_item(16'sh0000, 1'b0, 13'h0000);
    endtask

    task automatic test_random();
        logic signed [SB-1:0]         smp;
        logic                         mv;
        logic [acso_pkg::DRIVE_W-1:0] md;
        logic [acso_pkg::DRIVE_W-1:0] gain;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: gain = acso_pkg::DRIVE_MIN;
                1: gain = acso_pkg::DRIVE_MAX;
                2: gain = 13'd0;
                3: gain = 13'h1fff;
                4: gain = acso_pkg::DRIVE_RESET;
                default: begin
                    gain = ($urandom_range(1) == 0) ? 13'($urandom_range(600))
                                                     : 13'($urandom_range(8191));
                end
            endcase
            write_drive_gain(gain);
            quiet_mode = (p == 5) || (p == 6);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(9))
                    0: begin
                        case ($urandom_range(3))
                            0: smp = 16'sh7fff;
                            1: smp = 16'sh8000;
                            2: smp = 16'sh0000;
                            default: smp = ($urandom_range(1) == 0) ? 16'sh0001 : 16'shffff;
                        endcase
                    end
                    1, 2: smp = 16'($urandom_range(511)) - 16'sd256;
                    default: smp = 16'($urandom);
                endcase
                mv = ($urandom_range(11) == 0);
                case ($urandom_range(9))
                    0: md = 13'($urandom_range(8191));
                    1, 2: md = 13'($urandom_range(300));
                    default: md = 13'($urandom_range(acso_pkg::DRIVE_MAX));
                endcase
                send_item(smp, mv, md);
            end
            quiet_mode = 1'b0;
        end
    endtask

    initial begin
        i_rst_n                = 1'b0;
        i_drive_gain_we        = 1'b0;
        i_drive_gain           = '0;
        sample_in_ch.valid     = 1'b0;
        sample_in_ch.sample_in = '0;
        sample_in_ch.mod_valid = 1'b0;
        sample_in_ch.mod_drive = '0;
        sample_out_ch.ready    = 1'b1;
        quiet_mode             = 1'b0;
        err_count              = 0;
        item_count             = 0;
        checked_count          = 0;
        gain_writes            = 0;
        mod_items              = 0;
        drive_now              = acso_pkg::DRIVE_RESET;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_drive();
        test_drive_register();
        test_mod_drive();
        test_random();

        wait_drained();
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("run covered %0d items and %0d checked results", item_count, checked_count);
        $display("drive register written %0d times, %0d items with modulated drive",
                 gain_writes, mod_items);
        if (err_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("%0d mismatches", err_count);
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
